// ----- hdl/ptu_pkg.sv -----
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared widths, codes, transfer payload types and helpers of the penalty
// thresholding unit.
// ----------------------------------------------------------------------------
package ptu_pkg;

  localparam int DATA_W        = 32;
  localparam int LAM_W         = 31;
  localparam int KIND_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int GL1_W         = 2 * LAM_W;
  localparam int N2_W          = 65;
  localparam int QUO2_W        = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [LAM_W-1:0] GAMMA_RST = LAM_W'(196608);

  localparam logic [KIND_W-1:0] KIND_LASSO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MCP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd1;

  typedef enum logic [2:0] {
    OP_ZERO,
    OP_BAD,
    OP_DIRECT,
    OP_DIV,
    OP_SCAD
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              neg;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    logic [GL1_W-1:0]  gl1;
  } q_entry_t;

  typedef struct packed {
    op_e               op;
    logic              neg;
    logic              sat;
    logic [DATA_W-1:0] num;
  } mid_t;

  typedef struct packed {
    logic              busy;
    logic              bad;
    logic [QUO2_W-1:0] inv;
  } rcp_stat_t;

  function automatic logic [DATA_W-1:0] saturate(input logic neg, input logic [DATA_W:0] mag);
    logic [DATA_W:0] lim;
    logic [DATA_W:0] m;
    logic [DATA_W:0] t;
    lim = {2'b01, {(DATA_W-1){1'b0}}};
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      t = (DATA_W+1)'(0) - m;
      return t[DATA_W-1:0];
    end
    m = (mag > (lim - 1'b1)) ? (lim - 1'b1) : mag;
    return m[DATA_W-1:0];
  endfunction

endpackage

// ----- hdl/ptu_if.sv -----
// ----------------------------------------------------------------------------
// ptu_if
// Valid/ready channels of the penalty thresholding unit.
// ----------------------------------------------------------------------------
interface ptu_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptu_pkg::DATA_W-1:0]   z_value;
  logic        [ptu_pkg::LAM_W-1:0]    lambda_one;
  logic        [ptu_pkg::LAM_W-1:0]    lambda_two;

  modport source (output valid, z_value, lambda_one, lambda_two, input ready);
  modport sink   (input valid, z_value, lambda_one, lambda_two, output ready);
endinterface

interface ptu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptu_pkg::DATA_W-1:0]   shrunk_value;
  logic                                bad_denominator;

  modport source (output valid, shrunk_value, bad_denominator, input ready);
  modport sink   (input valid, shrunk_value, bad_denominator, output ready);
endinterface

// ----- hdl/penalty_thresholding_unit_core.sv -----
// ----------------------------------------------------------------------------
// penalty_thresholding_unit_core
// Lasso / MCP / SCAD shrinkage of one signed fixed-point value per transfer.
//
//   channel  dir  handshake         payload
//   in_i     in   valid/ready       z_value, lambda_one, lambda_two
//   res_o    out  valid/ready       shrunk_value, bad_denominator
//   cfg      in   cfg_we_i only     cfg_idx_i, cfg_data_i
//
// One transfer per cycle sustained while res_o is ready and the gamma
// reciprocal is idle; results pass the front end, queue, both bit-per-stage
// divider pipelines and output register. After reset and after each register
// write the sequential divider recomputes the reciprocal; in_i.ready is low
// meanwhile. A stalled res_o freezes the back end; the 4-entry queue keeps
// the front end taking transfers until it fills.
// ----------------------------------------------------------------------------
module penalty_thresholding_unit_core #(
  parameter int FRAC_BITS = ptu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ptu_in_if.sink                          in_i,
  ptu_out_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [ptu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptu_pkg::LAM_W-1:0]       cfg_data_i
);

  localparam logic [ptu_pkg::LAM_W-1:0] QONE = ptu_pkg::LAM_W'(1) << FRAC_BITS;

  logic [ptu_pkg::KIND_W-1:0] kind_q;
  logic [ptu_pkg::LAM_W-1:0]  gamma_q;
  ptu_pkg::rcp_stat_t         rcp;
  ptu_pkg::q_entry_t          push_data, pop_data;
  logic                       push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= ptu_pkg::KIND_LASSO;
      gamma_q <= ptu_pkg::GAMMA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptu_pkg::REG_KIND:  kind_q  <= cfg_data_i[ptu_pkg::KIND_W-1:0];
        ptu_pkg::REG_GAMMA: gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptu_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .kind_i  (kind_q),
    .gamma_i (gamma_q),
    .stat_o  (rcp)
  );

  ptu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_we_i (cfg_we_i),
    .kind_i   (kind_q),
    .gamma_i  (gamma_q),
    .rcp_i    (rcp),
    .full_i   (full),
    .pop_i    (pop),
    .push_o   (push),
    .entry_o  (push_data)
  );

  ptu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .full_o  (full),
    .empty_o (empty)
  );

  ptu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (pop_data),
    .avail_i (!empty),
    .pop_o   (pop),
    .gm1_i   (gamma_q - QONE),
    .out_o   (res_o)
  );

endmodule

// ----- hdl/ptu_recip.sv -----
// ----------------------------------------------------------------------------
// ptu_recip
// Iterative reciprocal of gamma (or gamma - 1) in fixed point, one quotient
// bit per cycle, rerun after reset and after every register write.
// ----------------------------------------------------------------------------
module ptu_recip #(
  parameter int FRAC_BITS = ptu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptu_pkg::KIND_W-1:0]    kind_i,
  input  logic [ptu_pkg::LAM_W-1:0]     gamma_i,
  output ptu_pkg::rcp_stat_t            stat_o
);

  localparam int RW  = 2 * FRAC_BITS + 1;
  localparam int SW  = ptu_pkg::LAM_W + ptu_pkg::QUO2_W;
  localparam int CW  = $clog2(ptu_pkg::QUO2_W);
  localparam logic [RW-1:0] NUM = RW'(1) << (2 * FRAC_BITS);
  localparam logic [ptu_pkg::LAM_W-1:0] QONE = ptu_pkg::LAM_W'(1) << FRAC_BITS;

  logic                        pend_q, pend_d;
  logic                        run_q, run_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [RW-1:0]               rem_q, rem_d;
  logic [SW-1:0]               sh_q, sh_d;
  logic [ptu_pkg::QUO2_W-1:0]  quo_q, quo_d;
  logic                        bad_q, bad_d;
  logic [ptu_pkg::LAM_W-1:0]   dv;

  always_comb begin
    if (kind_i == ptu_pkg::KIND_SCAD) begin
      dv = (gamma_i > QONE) ? (gamma_i - QONE) : '0;
    end else begin
      dv = gamma_i;
    end
  end

  always_comb begin
    pend_d = pend_q;
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    bad_d  = bad_q;
    if (pend_q) begin
      pend_d = 1'b0;
      run_d  = 1'b1;
      cnt_d  = CW'(ptu_pkg::QUO2_W - 1);
      rem_d  = NUM;
      sh_d   = SW'(dv) << (ptu_pkg::QUO2_W - 1);
      quo_d  = '0;
      bad_d  = (dv == '0) || (SW'(NUM >> ptu_pkg::QUO2_W) >= SW'(dv));
    end else if (run_q) begin
      if (SW'(rem_q) >= sh_q) begin
        rem_d        = rem_q - sh_q[RW-1:0];
        quo_d[cnt_q] = 1'b1;
      end
      sh_d  = sh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end
    end
    if (start_i) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      run_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      run_q  <= run_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    bad_q <= bad_d;
  end

  assign stat_o.busy = pend_q || run_q;
  assign stat_o.bad  = bad_q;
  assign stat_o.inv  = quo_q;

endmodule

// ----- hdl/ptu_front.sv -----
// ----------------------------------------------------------------------------
// ptu_front
// Takes input transfers, forms |z|, the region bounds and the divisor, and
// classifies each item into an operation for the back end.
// ----------------------------------------------------------------------------
module ptu_front #(
  parameter int FRAC_BITS = ptu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ptu_in_if.sink                        in_i,
  input  logic                          cfg_we_i,
  input  logic [ptu_pkg::KIND_W-1:0]    kind_i,
  input  logic [ptu_pkg::LAM_W-1:0]     gamma_i,
  input  ptu_pkg::rcp_stat_t            rcp_i,
  input  logic                          full_i,
  input  logic                          pop_i,
  output logic                          push_o,
  output ptu_pkg::q_entry_t             entry_o
);

  localparam int DW  = ptu_pkg::DATA_W;
  localparam int LW  = ptu_pkg::LAM_W;
  localparam int GW  = ptu_pkg::GL1_W;
  localparam int XW  = LW + DW;
  localparam int TW  = 64;
  localparam int PW  = DW + 1;
  localparam int BW  = PW + DW;
  localparam logic [DW-1:0] QONE = DW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] PCAP = {1'b1, {DW{1'b0}}};

  logic en_f, acc;
  logic v1_q, v2_q, v3_q;

  logic [DW-1:0] z1_q;
  logic [LW-1:0] l11_q, l21_q;

  logic          neg2_q;
  logic [DW-1:0] a2_q, opl22_q;
  logic [LW-1:0] l12_q;
  logic [GW-1:0] gl12_q;
  logic [XW-1:0] l1x2_q;

  logic          neg3_q;
  logic [DW-1:0] a3_q, opl23_q;
  logic [LW-1:0] l13_q;
  logic [GW-1:0] gl13_q;
  logic [TW-1:0] t13_q;
  logic [BW-1:0] bp3_q;

  logic          neg1;
  logic [DW-1:0] a1, opl21;
  logic [GW-1:0] pr2;
  logic [PW-1:0] p2;

  logic [BW-1:0] bound3;
  logic [DW-1:0] am1;
  logic          mid_ok;

  assign en_f     = !v3_q || !full_i || pop_i;
  assign in_i.ready = en_f && !rcp_i.busy && !cfg_we_i;
  assign acc      = in_i.valid && in_i.ready;
  assign push_o   = v3_q && en_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_f) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign neg1  = z1_q[DW-1];
  assign a1    = neg1 ? (~z1_q + 1'b1) : z1_q;
  assign opl21 = QONE + DW'(l21_q);

  assign pr2 = gl12_q >> FRAC_BITS;
  assign p2  = (pr2 > GW'(PCAP)) ? PCAP : pr2[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      z1_q    <= in_i.z_value;
      l11_q   <= in_i.lambda_one;
      l21_q   <= in_i.lambda_two;

      neg2_q  <= neg1;
      a2_q    <= a1;
      opl22_q <= opl21;
      l12_q   <= l11_q;
      gl12_q  <= GW'(gamma_i) * GW'(l11_q);
      l1x2_q  <= XW'(l11_q) * XW'(opl21);

      neg3_q  <= neg2_q;
      a3_q    <= a2_q;
      opl23_q <= opl22_q;
      l13_q   <= l12_q;
      gl13_q  <= gl12_q;
      t13_q   <= TW'(l1x2_q >> FRAC_BITS) + TW'(l12_q);
      bp3_q   <= BW'(p2) * BW'(opl22_q);
    end
  end

  assign bound3 = bp3_q >> FRAC_BITS;
  assign am1    = a3_q - DW'(l13_q);
  assign mid_ok = !rcp_i.bad && (opl23_q > rcp_i.inv);

  always_comb begin
    entry_o.op  = ptu_pkg::OP_ZERO;
    entry_o.neg = neg3_q;
    entry_o.a   = a3_q;
    entry_o.num = a3_q;
    entry_o.den = opl23_q;
    entry_o.gl1 = gl13_q;
    if (a3_q > DW'(l13_q)) begin
      unique case (kind_i)
        ptu_pkg::KIND_MCP: begin
          if (BW'(a3_q) <= bound3) begin
            entry_o.op  = mid_ok ? ptu_pkg::OP_DIV : ptu_pkg::OP_BAD;
            entry_o.num = am1;
            entry_o.den = opl23_q - rcp_i.inv;
          end else begin
            entry_o.op  = ptu_pkg::OP_DIV;
          end
        end
        ptu_pkg::KIND_SCAD: begin
          if (TW'(a3_q) <= t13_q) begin
            entry_o.op  = ptu_pkg::OP_DIV;
            entry_o.num = am1;
          end else if (BW'(a3_q) <= bound3) begin
            entry_o.op  = mid_ok ? ptu_pkg::OP_SCAD : ptu_pkg::OP_BAD;
            entry_o.den = opl23_q - rcp_i.inv;
          end else begin
            entry_o.op  = ptu_pkg::OP_DIV;
          end
        end
        default: begin
          entry_o.op  = ptu_pkg::OP_DIRECT;
          entry_o.num = am1;
        end
      endcase
    end
  end

endmodule

// ----- hdl/ptu_queue.sv -----
// ----------------------------------------------------------------------------
// ptu_queue
// Short FIFO between the classify front end and the divide back end.
// ----------------------------------------------------------------------------
module ptu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ptu_pkg::q_entry_t   data_i,
  input  logic                pop_i,
  output ptu_pkg::q_entry_t   data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int DEPTH = ptu_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  ptu_pkg::q_entry_t mem_q [DEPTH];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/ptu_divpipe.sv -----
// ----------------------------------------------------------------------------
// ptu_divpipe
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag when the quotient does not fit in QW bits. Payload rides alongside.
// ----------------------------------------------------------------------------
module ptu_divpipe #(
  parameter int  NW = 62,
  parameter int  DW = 31,
  parameter int  QW = 49,
  parameter type PL_T = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  PL_T           pl_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          big_o,
  output PL_T           pl_o
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW:0]   v_q;
  logic [QW:0]   big_q;
  logic [NW-1:0] r_q [QW];
  logic [DW-1:0] d_q [QW];
  logic [QW-1:0] q_q [QW+1];
  PL_T           pl_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_i;
      d_q[0]   <= den_i;
      q_q[0]   <= '0;
      big_q[0] <= (num_i >> QW) >= NW'(den_i);
      pl_q[0]  <= pl_i;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    localparam int K = QW - i;
    logic [XW-1:0] trial;
    logic [XW-1:0] diff;
    logic          ge;

    assign trial = XW'(d_q[i-1]) << K;
    assign ge    = XW'(r_q[i-1]) >= trial;
    assign diff  = XW'(r_q[i-1]) - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i]   <= q_q[i-1] | (ge ? (QW'(1) << K) : '0);
        big_q[i] <= big_q[i-1];
        pl_q[i]  <= pl_q[i-1];
      end
    end

    if (i < QW) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i] <= ge ? diff[NW-1:0] : r_q[i-1];
          d_q[i] <= d_q[i-1];
        end
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = q_q[QW];
  assign big_o   = big_q[QW];
  assign pl_o    = pl_q[QW];

endmodule

// ----- hdl/ptu_back.sv -----
// ----------------------------------------------------------------------------
// ptu_back
// Carries out the classified operations: the SCAD offset divide, the main
// divide, sign and saturation, and the output register.
// ----------------------------------------------------------------------------
module ptu_back #(
  parameter int FRAC_BITS = ptu_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptu_pkg::q_entry_t            entry_i,
  input  logic                         avail_i,
  output logic                         pop_o,
  input  logic [ptu_pkg::LAM_W-1:0]    gm1_i,
  ptu_out_if.source                    out_o
);

  localparam int DW  = ptu_pkg::DATA_W;
  localparam int GW  = ptu_pkg::GL1_W;
  localparam int NW2 = ptu_pkg::N2_W;
  localparam int QW1 = NW2 - FRAC_BITS;
  localparam int QW2 = ptu_pkg::QUO2_W;

  logic en_b;
  logic out_vld_q;
  logic [DW-1:0] out_val_q;
  logic out_bad_q;

  logic              v1;
  logic [QW1-1:0]    c1;
  logic              big1;
  ptu_pkg::q_entry_t e1;

  ptu_pkg::mid_t     mid;
  logic [NW2-1:0]    n2;
  logic [QW1-1:0]    a_ext;
  logic [QW1-1:0]    mag;

  logic              v2;
  logic [QW2-1:0]    q2;
  logic              big2;
  ptu_pkg::mid_t     p2;

  logic [DW-1:0]     res;
  logic              bad;

  assign en_b  = !out_vld_q || out_o.ready;
  assign pop_o = en_b && avail_i;

  ptu_divpipe #(
    .NW(GW), .DW(ptu_pkg::LAM_W), .QW(QW1), .PL_T(ptu_pkg::q_entry_t)
  ) u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_b),
    .valid_i (avail_i),
    .num_i   ((entry_i.gl1 >> FRAC_BITS) << FRAC_BITS),
    .den_i   (gm1_i),
    .pl_i    (entry_i),
    .valid_o (v1),
    .quo_o   (c1),
    .big_o   (big1),
    .pl_o    (e1)
  );

  assign a_ext = QW1'(e1.a);

  always_comb begin
    mid.op  = e1.op;
    mid.neg = e1.neg;
    mid.sat = 1'b0;
    mid.num = e1.num;
    mag     = '0;
    n2      = NW2'(e1.num) << FRAC_BITS;
    if (e1.op == ptu_pkg::OP_SCAD) begin
      if (big1) begin
        mid.sat = 1'b1;
        mid.neg = ~e1.neg;
      end else if (a_ext >= c1) begin
        mag = a_ext - c1;
      end else begin
        mag     = c1 - a_ext;
        mid.neg = ~e1.neg;
      end
      n2 = NW2'(mag) << FRAC_BITS;
    end
  end

  ptu_divpipe #(
    .NW(NW2), .DW(DW), .QW(QW2), .PL_T(ptu_pkg::mid_t)
  ) u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_b),
    .valid_i (v1),
    .num_i   (n2),
    .den_i   (e1.den),
    .pl_i    (mid),
    .valid_o (v2),
    .quo_o   (q2),
    .big_o   (big2),
    .pl_o    (p2)
  );

  always_comb begin
    res = '0;
    bad = 1'b0;
    case (p2.op)
      ptu_pkg::OP_ZERO: begin
        res = '0;
      end
      ptu_pkg::OP_BAD: begin
        bad = 1'b1;
      end
      ptu_pkg::OP_DIRECT: begin
        res = ptu_pkg::saturate(p2.neg, {1'b0, p2.num});
      end
      default: begin
        res = ptu_pkg::saturate(p2.neg,
                (p2.sat || big2) ? {1'b1, {DW{1'b0}}} : (DW+1)'(q2));
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_b) begin
      out_vld_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      out_val_q <= res;
      out_bad_q <= bad;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.shrunk_value    = out_val_q;
  assign out_o.bad_denominator = out_bad_q;

endmodule
